### hdl/page_free_list_allocator_assert.svh
// Assertion macros for the page free-list allocator checker.
// Depends on nothing; expects clk and rst_n in the scope of use.
`ifndef PAGE_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define PAGE_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PFL_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfl assertion failed");

// Next-cycle implication, disabled while in reset.
`define PFL_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfl assertion failed");

`endif

### hdl/pfl_pkg.sv
// Shared constants for the page free-list allocator.
// No dependencies.
package pfl_pkg;

  localparam int PAGE_W  = 10;
  localparam int COUNT_W = 11;
  localparam int CMP_W   = 17;  // holds any store size up to 131071

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_TOUCH = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FREE_REJ = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;

  localparam logic [PAGE_W-1:0] RESV_RESET = 10'd33;

endpackage

### hdl/pfl_link_ram.sv
// Next-link table: one write port, one read port, registered read data.
// Uses pfl_pkg for the page width.
module pfl_link_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [pfl_pkg::PAGE_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [pfl_pkg::PAGE_W-1:0] rdata
);

  logic [pfl_pkg::PAGE_W-1:0] mem [DEPTH];
  logic [pfl_pkg::PAGE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/page_free_list_allocator.sv
// Page allocator with a LIFO free list threaded through a next-link table.
// Depends on pfl_pkg and pfl_link_ram.
//
// Usage:
//  - Request channel: present in_mode/in_page with start; the item is taken
//    at a rising edge where start is high and busy is low.
//    in_mode: allocate, free page, touch page.
//  - Result channel: one item per request on out_page_out/out_reused/
//    out_status, valid for exactly one cycle under out_valid. The receiver
//    cannot stall; results are never held.
//  - Config channel: cfg_valid/cfg_ready write reserved_pages. Only written
//    while idle; cfg_ready is low while a pop is in flight.
//  - Each result is registered and appears the cycle after acceptance.
//  - Throughput: one item per cycle for free, touch, proposing allocate and
//    rejects; an allocate that pops the list raises busy, since the next
//    link of the old head comes from the synchronous link table and must
//    land in the head register before the following request.
//  - Reset (rst_n low, synchronous): empty list, page count 0,
//    reserved_pages 33, no result pending. The link table is not cleared:
//    only entries written by a free are ever read.
module page_free_list_allocator #(
  parameter int STORE_PAGES = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // request
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_mode,
  input  logic [pfl_pkg::PAGE_W-1:0] in_page,
  // result
  output logic                       out_valid,
  output logic [pfl_pkg::PAGE_W-1:0] out_page_out,
  output logic                       out_reused,
  output logic [1:0]                 out_status,
  // configuration
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [pfl_pkg::PAGE_W-1:0] cfg_reserved_pages
);

  // Only pages below 1024 can ever be addressed, so the table stops there.
  localparam int DEPTH = (STORE_PAGES < 1024) ? STORE_PAGES : 1024;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [pfl_pkg::CMP_W-1:0] NP_C = pfl_pkg::CMP_W'(STORE_PAGES);

  typedef enum logic {ST_IDLE, ST_POP} state_t;

  state_t                        state_r;
  logic                          out_valid_r;
  logic [pfl_pkg::PAGE_W-1:0]    out_page_r;
  logic                          out_reused_r;
  logic [1:0]                    out_status_r;
  logic [pfl_pkg::PAGE_W-1:0]    resv_r;
  logic [pfl_pkg::PAGE_W-1:0]    head_r, head_nxt;
  logic [pfl_pkg::COUNT_W-1:0]   count_r, count_nxt;

  logic                          accept;
  logic                          head_ok, pop, free_ok, page_in_range, full;
  logic [pfl_pkg::COUNT_W-1:0]   prop, resv_ext, cover_plus1;
  logic [pfl_pkg::PAGE_W-1:0]    cover_pg;
  logic                          cover_en;
  logic [pfl_pkg::PAGE_W-1:0]    res_page;
  logic                          res_reused;
  logic [1:0]                    res_status;
  logic                          ram_we, ram_re;
  logic [pfl_pkg::PAGE_W-1:0]    ram_rdata;

  assign busy      = (state_r == ST_POP);
  assign cfg_ready = (state_r == ST_IDLE);
  assign accept    = start && !busy;

  // Head is poppable only when listed, unreserved and inside the store.
  assign head_ok = (head_r != '0) && (head_r >= resv_r)
                   && ({{(pfl_pkg::CMP_W-pfl_pkg::PAGE_W){1'b0}}, head_r} < NP_C);
  assign page_in_range =
    ({{(pfl_pkg::CMP_W-pfl_pkg::PAGE_W){1'b0}}, in_page} < NP_C);
  assign free_ok = (in_page != '0) && (in_page >= resv_r) && page_in_range;

  // Proposal for an allocate that cannot pop: max(reserved, page count).
  assign resv_ext = {1'b0, resv_r};
  assign prop     = (count_r > resv_ext) ? count_r : resv_ext;
  assign full     = ({{(pfl_pkg::CMP_W-pfl_pkg::COUNT_W){1'b0}}, prop} >= NP_C);

  assign pop = (in_mode == pfl_pkg::MODE_ALLOC) && head_ok;

  always_comb begin
    res_page   = in_page;
    res_reused = 1'b0;
    res_status = pfl_pkg::STAT_OK;
    cover_en   = 1'b0;
    cover_pg   = in_page;
    unique case (in_mode)
      pfl_pkg::MODE_ALLOC: begin
        if (head_ok) begin
          res_page   = head_r;
          res_reused = 1'b1;
          cover_en   = 1'b1;
          cover_pg   = head_r;
        end else begin
          res_page = prop[pfl_pkg::PAGE_W-1:0];
          if (full) begin
            res_status = pfl_pkg::STAT_FULL;
          end
        end
      end
      pfl_pkg::MODE_FREE: begin
        if (free_ok) begin
          cover_en = 1'b1;
        end else begin
          res_status = pfl_pkg::STAT_FREE_REJ;
        end
      end
      pfl_pkg::MODE_TOUCH: begin
        cover_en = page_in_range;
      end
      default: begin
        // unused mode: echo only
      end
    endcase
  end

  // Page count rises to cover the handled page.
  assign cover_plus1 = {1'b0, cover_pg} + pfl_pkg::COUNT_W'(1);
  always_comb begin
    count_nxt = count_r;
    if (accept && cover_en && (cover_plus1 > count_r)) begin
      count_nxt = cover_plus1;
    end
  end

  // Free pushes: link the old head behind the page. Pop: the next link is
  // read and loaded in ST_POP, while busy blocks the next request.
  always_comb begin
    head_nxt = head_r;
    priority if (state_r == ST_POP) begin
      head_nxt = ram_rdata;
    end else if (accept && (in_mode == pfl_pkg::MODE_FREE) && free_ok) begin
      head_nxt = in_page;
    end
  end

  assign ram_we = accept && (in_mode == pfl_pkg::MODE_FREE) && free_ok;
  assign ram_re = accept && pop;

  pfl_link_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_page[AW-1:0]),
    .wdata (head_r),
    .re    (ram_re),
    .raddr (head_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      resv_r      <= pfl_pkg::RESV_RESET;
      head_r      <= '0;
      count_r     <= '0;
    end else begin
      out_valid_r <= accept;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        resv_r <= cfg_reserved_pages;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (ram_re) begin
            state_r <= ST_POP;
          end
        end
        ST_POP: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
    // payload needs no reset
    if (accept) begin
      out_page_r   <= res_page;
      out_reused_r <= res_reused;
      out_status_r <= res_status;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_page_out = out_page_r;
  assign out_reused   = out_reused_r;
  assign out_status   = out_status_r;

endmodule

### hdl/pfl_checker.sv
// Port-level checks for page_free_list_allocator, bound into that module.
// Depends on pfl_pkg and page_free_list_allocator_assert.svh.
`include "page_free_list_allocator_assert.svh"

module pfl_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic [1:0]                 in_mode,
  input logic                       out_valid,
  input logic                       out_reused,
  input logic [1:0]                 out_status
);

  // every accepted item yields its result in the next cycle
  `PFL_AST_NXT(a_result_follows, start && !busy, out_valid)
  // no result without an accepted item
  `PFL_AST_IMP(a_no_spurious, out_valid, $past(start && !busy))
  // a pop holds off requests for a single cycle only
  `PFL_AST_NXT(a_busy_one_cycle, busy, !busy)
  // a reject only answers a free request
  `PFL_AST_IMP(a_reject_on_free, out_valid && (out_status == pfl_pkg::STAT_FREE_REJ),
               $past(in_mode) == pfl_pkg::MODE_FREE)
  // a reused page is always a clean allocate
  `PFL_AST_IMP(a_reuse_ok, out_valid && out_reused,
               (out_status == pfl_pkg::STAT_OK) && ($past(in_mode) == pfl_pkg::MODE_ALLOC))

endmodule

bind page_free_list_allocator pfl_checker u_pfl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_mode    (in_mode),
  .out_valid  (out_valid),
  .out_reused (out_reused),
  .out_status (out_status)
);
